[rtl/hcb_pkg.sv]
// ----------------------------------------------------------------------------
// hcb_pkg: shared types and constants
// Widths, node store layout, controller states and the command/status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package hcb_pkg;

   localparam int MAX_SYMBOLS = 32;
   localparam int MAX_RADIX   = 16;
   localparam int MAX_NODES   = 64;

   localparam int WEIGHT_W  = 16;
   localparam int NWEIGHT_W = 22;
   localparam int KEY_W     = $clog2(MAX_NODES);
   localparam int DIGIT_W   = $clog2(MAX_RADIX);
   localparam int CNT_W     = KEY_W + 1;
   localparam int RADIX_W   = 5;
   localparam int SCOUNT_W  = 6;
   localparam int SYM_W     = 5;
   localparam int LEN_W     = 5;
   localparam int VAL_W     = 31;
   localparam int AVG_W     = 12;
   localparam int SUM_W     = 27;
   localparam int NUM_W     = 35;
   localparam int DEN_W     = NWEIGHT_W + 1;
   localparam int QCNT_W    = $clog2(AVG_W);
   localparam int CSR_IW    = 1;
   localparam int CSR_DW    = 6;
   localparam int HUNDRED   = 100;

   localparam logic [CSR_IW-1:0] REG_RADIX   = 1'b0;
   localparam logic [CSR_IW-1:0] REG_SYMBOLS = 1'b1;

   typedef struct packed {
      logic [NWEIGHT_W-1:0] weight;
      logic [KEY_W-1:0]     key;
      logic [KEY_W-1:0]     parent;
      logic [DIGIT_W-1:0]   digit;
   } node_type;

   typedef struct packed {
      logic [LEN_W-1:0] len;
      logic [VAL_W-1:0] val;
   } code_type;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_PAD,
      ST_SCAN,
      ST_COMMIT,
      ST_MERGE,
      ST_WALK_RD,
      ST_WALK_EX,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_EMIT_RD,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic pad;
      logic build_init;
      logic scan_clr;
      logic scan_step;
      logic commit;
      logic merge;
      logic walk_init;
      logic walk_ex;
      logic div_go;
      logic emit_rd;
      logic emit_next;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic cfg_write;
      logic last_load;
      logic need_pad;
      logic scan_done;
      logic take_last;
      logic merge_last;
      logic sym_done;
      logic sym_last;
      logic div_done;
      logic emit_last;
   } sts_type;

endpackage

`default_nettype wire

[rtl/hcb_if.sv]
// ----------------------------------------------------------------------------
// hcb_if: item channels
// Valid/ready channels for weights in and codes out.
// ----------------------------------------------------------------------------
`default_nettype none

interface hcb_req_if import hcb_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [WEIGHT_W-1:0] weight;

   modport source (output valid, output weight, input ready);
   modport sink   (input valid, input weight, output ready);
endinterface

interface hcb_rsp_if import hcb_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [SYM_W-1:0]   symbol;
   logic [LEN_W-1:0]   code_length;
   logic [VAL_W-1:0]   code_value;
   logic [AVG_W-1:0]   average_hundredths;
   logic               last;

   modport source (output valid, output symbol, output code_length, output code_value,
                   output average_hundredths, output last, input ready);
   modport sink   (input valid, input symbol, input code_length, input code_value,
                   input average_hundredths, input last, output ready);
endinterface

`default_nettype wire

[rtl/hcb_div.sv]
// ----------------------------------------------------------------------------
// hcb_div: restoring divider
// One quotient bit per cycle; quotient known to fit AVG_W bits.
// ----------------------------------------------------------------------------
`default_nettype none

module hcb_div import hcb_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [NUM_W-1:0] num,
   input  wire logic [DEN_W-1:0] den,
   output logic                  done,
   output logic [AVG_W-1:0]      quot
);

   logic [NUM_W-1:0]  rem_ff, rem_in;
   logic [DEN_W-1:0]  den_ff, den_in;
   logic [AVG_W-1:0]  q_ff, q_in;
   logic [QCNT_W-1:0] k_ff, k_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [NUM_W-1:0]  shifted;
   logic [NUM_W:0]    diff;

   assign shifted = NUM_W'(den_ff) << k_ff;
   assign diff    = {1'b0, rem_ff} - {1'b0, shifted};

   always_comb begin
      rem_in  = rem_ff;
      den_in  = den_ff;
      q_in    = q_ff;
      k_in    = k_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         rem_in  = num;
         den_in  = den;
         q_in    = '0;
         k_in    = QCNT_W'(AVG_W - 1);
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         if (!diff[NUM_W]) begin
            rem_in     = diff[NUM_W-1:0];
            q_in[k_ff] = 1'b1;
         end
         if (k_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            k_in = k_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      q_ff   <= q_in;
      k_ff   <= k_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quot = q_ff;

endmodule

`default_nettype wire

[rtl/hcb_datapath.sv]
// ----------------------------------------------------------------------------
// hcb_datapath: node store, min scan, code walk and averaging
// Executes controller commands; reports status back.
// ----------------------------------------------------------------------------
`default_nettype none

module hcb_datapath import hcb_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_we,
   input  wire logic [CSR_IW-1:0]   csr_index,
   input  wire logic [CSR_DW-1:0]   csr_wdata,
   input  wire logic [WEIGHT_W-1:0] weight,
   input  wire cmd_type             cmd,
   output sts_type                  sts,
   output logic [SYM_W-1:0]         symbol,
   output logic [LEN_W-1:0]         code_length,
   output logic [VAL_W-1:0]         code_value,
   output logic [AVG_W-1:0]         average_hundredths,
   output logic                     last
);

   logic [RADIX_W-1:0]  radix_ff, radix_in;
   logic [SCOUNT_W-1:0] scount_ff, scount_in;
   logic [RADIX_W-1:0]  r_eff;
   logic [SCOUNT_W-1:0] n_eff;
   logic                cfg_hit;

   node_type            node_mem [MAX_NODES];
   node_type            rd_ff;
   logic                mem_we;
   logic [KEY_W-1:0]    mem_wa, mem_ra;
   node_type            mem_wd;

   code_type            res_mem [MAX_SYMBOLS];
   code_type            res_rd_ff;

   logic [MAX_NODES-1:0] active_ff, active_in;
   logic [SCOUNT_W-1:0]  ld_ff, ld_in;
   logic [CNT_W-1:0]     nc_ff, nc_in;
   logic [DIGIT_W-1:0]   mod_ff, mod_in;
   logic [CNT_W-1:0]     act_ff, act_in;

   logic [CNT_W-1:0]     addr_ff, addr_in;
   logic                 svld_ff, svld_in;
   logic [KEY_W-1:0]     sidx_ff, sidx_in;
   logic                 found_ff, found_in;
   logic [KEY_W-1:0]     best_ff, best_in;
   logic [NWEIGHT_W-1:0] bw_ff, bw_in;
   logic [KEY_W-1:0]     bk_ff, bk_in;

   logic [DIGIT_W-1:0]   digit_ff, digit_in;
   logic [NWEIGHT_W-1:0] wsum_ff, wsum_in;
   logic [KEY_W-1:0]     mkey_ff, mkey_in;

   logic [SCOUNT_W-1:0]  sym_ff, sym_in;
   logic [KEY_W-1:0]     j_ff, j_in;
   logic [LEN_W-1:0]     len_ff, len_in;
   logic [VAL_W-1:0]     val_ff, val_in;
   logic [VAL_W-1:0]     mul_ff, mul_in;
   logic                 first_ff, first_in;
   logic [WEIGHT_W-1:0]  cw_ff, cw_in;
   logic [NWEIGHT_W-1:0] total_ff, total_in;
   logic [SUM_W-1:0]     wtd_ff, wtd_in;
   logic [SCOUNT_W-1:0]  emit_ff, emit_in;

   logic                 issue, better, div_done;
   logic [KEY_W-1:0]     root;
   logic [WEIGHT_W-1:0]  cw;
   logic [LEN_W-1:0]     len_new;
   logic [VAL_W-1:0]     val_new;
   logic [CNT_W-1:0]     act_next;
   logic [DIGIT_W-1:0]   mod_step;
   logic [AVG_W-1:0]     quot;
   logic [NUM_W-1:0]     div_num;

   assign r_eff = (radix_ff < RADIX_W'(2)) ? RADIX_W'(2) :
                  (radix_ff > RADIX_W'(MAX_RADIX)) ? RADIX_W'(MAX_RADIX) : radix_ff;
   assign n_eff = (scount_ff == '0) ? SCOUNT_W'(1) :
                  (scount_ff > SCOUNT_W'(MAX_SYMBOLS)) ? SCOUNT_W'(MAX_SYMBOLS) : scount_ff;
   assign cfg_hit = csr_we && (csr_index == REG_RADIX || csr_index == REG_SYMBOLS);

   always_comb begin
      radix_in  = radix_ff;
      scount_in = scount_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_RADIX:   radix_in  = csr_wdata[RADIX_W-1:0];
            REG_SYMBOLS: scount_in = csr_wdata[SCOUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // node store ports
   always_comb begin
      mem_we = 1'b0;
      mem_wa = nc_ff[KEY_W-1:0];
      mem_wd = '0;
      priority if (cmd.load) begin
         mem_we = 1'b1;
         mem_wa = ld_ff[KEY_W-1:0];
         mem_wd = '{weight: NWEIGHT_W'(weight), key: ld_ff[KEY_W-1:0], parent: '0,
                    digit: '0};
      end else if (cmd.pad) begin
         mem_we = 1'b1;
         mem_wd = '{weight: '0, key: nc_ff[KEY_W-1:0], parent: '0, digit: '0};
      end else if (cmd.commit) begin
         mem_we = 1'b1;
         mem_wa = best_ff;
         mem_wd = '{weight: bw_ff, key: bk_ff, parent: nc_ff[KEY_W-1:0], digit: digit_ff};
      end else if (cmd.merge) begin
         mem_we = 1'b1;
         mem_wd = '{weight: wsum_ff, key: mkey_ff, parent: '0, digit: '0};
      end else begin
         mem_we = 1'b0;
      end
   end

   assign mem_ra = cmd.scan_step ? addr_ff[KEY_W-1:0] : j_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         node_mem[mem_wa] <= mem_wd;
      end
      rd_ff <= node_mem[mem_ra];
   end

   assign issue    = addr_ff < nc_ff;
   assign better   = (rd_ff.weight < bw_ff) || (rd_ff.weight == bw_ff && rd_ff.key < bk_ff);
   assign root     = nc_ff[KEY_W-1:0] - 1'b1;
   assign act_next = act_ff - CNT_W'(r_eff - 1'b1);
   assign mod_step = (RADIX_W'(mod_ff) == r_eff - RADIX_W'(2)) ? '0 : mod_ff + 1'b1;
   assign cw       = first_ff ? rd_ff.weight[WEIGHT_W-1:0] : cw_ff;
   assign len_new  = len_ff + 1'b1;
   assign val_new  = val_ff + VAL_W'(rd_ff.digit * mul_ff);

   always_comb begin
      active_in = active_ff;
      ld_in     = ld_ff;
      nc_in     = nc_ff;
      mod_in    = mod_ff;
      act_in    = act_ff;
      addr_in   = addr_ff;
      svld_in   = 1'b0;
      sidx_in   = sidx_ff;
      found_in  = found_ff;
      best_in   = best_ff;
      bw_in     = bw_ff;
      bk_in     = bk_ff;
      digit_in  = digit_ff;
      wsum_in   = wsum_ff;
      mkey_in   = mkey_ff;
      sym_in    = sym_ff;
      j_in      = j_ff;
      len_in    = len_ff;
      val_in    = val_ff;
      mul_in    = mul_ff;
      first_in  = first_ff;
      cw_in     = cw_ff;
      total_in  = total_ff;
      wtd_in    = wtd_ff;
      emit_in   = emit_ff;

      if (cmd.load) begin
         active_in[ld_ff[KEY_W-1:0]] = 1'b1;
         ld_in  = ld_ff + 1'b1;
         nc_in  = CNT_W'(ld_ff) + 1'b1;
         mod_in = (ld_ff == '0) ? '0 : mod_step;
      end
      if (cmd.pad) begin
         active_in[nc_ff[KEY_W-1:0]] = 1'b1;
         nc_in  = nc_ff + 1'b1;
         mod_in = mod_step;
      end
      if (cmd.build_init) begin
         act_in   = nc_ff;
         digit_in = '0;
         wsum_in  = '0;
         mkey_in  = '1;
      end
      if (cmd.scan_clr) begin
         addr_in  = '0;
         found_in = 1'b0;
      end
      if (cmd.scan_step) begin
         if (issue) begin
            addr_in = addr_ff + 1'b1;
            svld_in = 1'b1;
            sidx_in = addr_ff[KEY_W-1:0];
         end
         if (svld_ff && active_ff[sidx_ff] && (!found_ff || better)) begin
            found_in = 1'b1;
            best_in  = sidx_ff;
            bw_in    = rd_ff.weight;
            bk_in    = rd_ff.key;
         end
      end
      if (cmd.commit) begin
         active_in[best_ff] = 1'b0;
         wsum_in  = wsum_ff + bw_ff;
         mkey_in  = (bk_ff < mkey_ff) ? bk_ff : mkey_ff;
         digit_in = digit_ff + 1'b1;
      end
      if (cmd.merge) begin
         active_in[nc_ff[KEY_W-1:0]] = 1'b1;
         nc_in    = nc_ff + 1'b1;
         act_in   = act_next;
         digit_in = '0;
         wsum_in  = '0;
         mkey_in  = '1;
      end
      if (cmd.walk_init) begin
         sym_in   = '0;
         j_in     = '0;
         len_in   = '0;
         val_in   = '0;
         mul_in   = VAL_W'(1);
         first_in = 1'b1;
         total_in = '0;
         wtd_in   = '0;
         emit_in  = '0;
      end
      if (cmd.walk_ex) begin
         if (rd_ff.parent == root) begin
            total_in = total_ff + NWEIGHT_W'(cw);
            wtd_in   = wtd_ff + SUM_W'(cw) * SUM_W'(len_new);
            sym_in   = sym_ff + 1'b1;
            j_in     = KEY_W'(sym_ff) + 1'b1;
            len_in   = '0;
            val_in   = '0;
            mul_in   = VAL_W'(1);
            first_in = 1'b1;
         end else begin
            j_in     = rd_ff.parent;
            len_in   = len_new;
            val_in   = val_new;
            mul_in   = VAL_W'(mul_ff * r_eff);
            first_in = 1'b0;
            cw_in    = cw;
         end
      end
      if (cmd.emit_next) begin
         emit_in = emit_ff + 1'b1;
      end
      if (cmd.finish || cfg_hit) begin
         active_in = '0;
         ld_in     = '0;
         nc_in     = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.walk_ex && rd_ff.parent == root) begin
         res_mem[sym_ff[SYM_W-1:0]] <= '{len: len_new, val: val_new};
      end
      if (cmd.emit_rd) begin
         res_rd_ff <= res_mem[emit_ff[SYM_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      mod_ff   <= mod_in;
      act_ff   <= act_in;
      addr_ff  <= addr_in;
      sidx_ff  <= sidx_in;
      best_ff  <= best_in;
      bw_ff    <= bw_in;
      bk_ff    <= bk_in;
      digit_ff <= digit_in;
      wsum_ff  <= wsum_in;
      mkey_ff  <= mkey_in;
      sym_ff   <= sym_in;
      j_ff     <= j_in;
      len_ff   <= len_in;
      val_ff   <= val_in;
      mul_ff   <= mul_in;
      first_ff <= first_in;
      cw_ff    <= cw_in;
      total_ff <= total_in;
      wtd_ff   <= wtd_in;
      emit_ff  <= emit_in;
      if (reset) begin
         radix_ff  <= RADIX_W'(2);
         scount_ff <= SCOUNT_W'(1);
         active_ff <= '0;
         ld_ff     <= '0;
         nc_ff     <= '0;
         svld_ff   <= 1'b0;
         found_ff  <= 1'b0;
      end else begin
         radix_ff  <= radix_in;
         scount_ff <= scount_in;
         active_ff <= active_in;
         ld_ff     <= ld_in;
         nc_ff     <= nc_in;
         svld_ff   <= svld_in;
         found_ff  <= found_in;
      end
   end

   // round(100 * weighted / total) = (200 * weighted + total) / (2 * total)
   assign div_num = NUM_W'(wtd_ff) * NUM_W'(2 * HUNDRED) + NUM_W'(total_ff);

   hcb_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_go),
      .num   (div_num),
      .den   ({total_ff, 1'b0}),
      .done  (div_done),
      .quot  (quot)
   );

   always_comb begin
      sts.cfg_write  = cfg_hit;
      sts.last_load  = (ld_ff == n_eff - 1'b1);
      sts.need_pad   = (nc_ff < CNT_W'(r_eff)) || (mod_ff != '0);
      sts.scan_done  = !issue && !svld_ff;
      sts.take_last  = (RADIX_W'(digit_ff) == r_eff - 1'b1);
      sts.merge_last = (act_next == CNT_W'(1));
      sts.sym_done   = (rd_ff.parent == root);
      sts.sym_last   = (sym_ff == n_eff - 1'b1);
      sts.div_done   = div_done;
      sts.emit_last  = (emit_ff == n_eff - 1'b1);
   end

   assign symbol             = emit_ff[SYM_W-1:0];
   assign code_length        = res_rd_ff.len;
   assign code_value         = res_rd_ff.val;
   assign average_hundredths = (total_ff == '0) ? '0 : quot;
   assign last               = (emit_ff == n_eff - 1'b1);

`ifndef NO_ASSERTIONS
   a_nodes_fit: assert property (@(posedge clock) disable iff (reset)
      nc_ff <= CNT_W'(MAX_NODES))
      else $error("node count beyond store");
   a_commit_live: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> found_ff && active_ff[best_ff])
      else $error("commit of an inactive node");
   a_commit_retires: assert property (@(posedge clock) disable iff (reset)
      cmd.commit && !cfg_hit |=> !active_ff[$past(best_ff)])
      else $error("taken node still active");
   a_merge_count: assert property (@(posedge clock) disable iff (reset)
      cmd.merge |-> act_ff > CNT_W'(1))
      else $error("merge with a single active node");
`endif

endmodule

`default_nettype wire

[rtl/hcb_ctrl.sv]
// ----------------------------------------------------------------------------
// hcb_ctrl: sequencer
// Load, pad, take/merge loop, code walk, divide and emit.
// ----------------------------------------------------------------------------
`default_nettype none

module hcb_ctrl import hcb_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   input  wire sts_type sts,
   output cmd_type      cmd
);

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD:     if (req_valid && sts.last_load) state_in = ST_PAD;
         ST_PAD:      if (!sts.need_pad) state_in = ST_SCAN;
         ST_SCAN:     if (sts.scan_done) state_in = ST_COMMIT;
         ST_COMMIT:   state_in = sts.take_last ? ST_MERGE : ST_SCAN;
         ST_MERGE:    state_in = sts.merge_last ? ST_WALK_RD : ST_SCAN;
         ST_WALK_RD:  state_in = ST_WALK_EX;
         ST_WALK_EX:  state_in = (sts.sym_done && sts.sym_last) ? ST_DIV_GO : ST_WALK_RD;
         ST_DIV_GO:   state_in = ST_DIV_WAIT;
         ST_DIV_WAIT: if (sts.div_done) state_in = ST_EMIT_RD;
         ST_EMIT_RD:  state_in = ST_EMIT;
         ST_EMIT:     if (rsp_ready) state_in = sts.emit_last ? ST_LOAD : ST_EMIT_RD;
         default:     state_in = ST_LOAD;
      endcase
      if (sts.cfg_write) begin
         state_in = ST_LOAD;
      end
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_LOAD: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_PAD: begin
            cmd.pad        = sts.need_pad;
            cmd.build_init = !sts.need_pad;
            cmd.scan_clr   = !sts.need_pad;
         end
         ST_SCAN:   cmd.scan_step = 1'b1;
         ST_COMMIT: begin
            cmd.commit   = 1'b1;
            cmd.scan_clr = 1'b1;
         end
         ST_MERGE: begin
            cmd.merge     = 1'b1;
            cmd.scan_clr  = 1'b1;
            cmd.walk_init = sts.merge_last;
         end
         ST_WALK_RD:  ;
         ST_WALK_EX:  cmd.walk_ex = 1'b1;
         ST_DIV_GO:   cmd.div_go = 1'b1;
         ST_DIV_WAIT: ;
         ST_EMIT_RD:  cmd.emit_rd = 1'b1;
         ST_EMIT: begin
            rsp_valid     = 1'b1;
            cmd.emit_next = rsp_ready && !sts.emit_last;
            cmd.finish    = rsp_ready && sts.emit_last;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_load_only_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> state_ff == ST_LOAD)
      else $error("weight taken outside load");
   a_emit_to_load: assert property (@(posedge clock) disable iff (reset)
      cmd.finish && !sts.cfg_write |=> state_ff == ST_LOAD && req_ready)
      else $error("set end did not return to load");
   a_div_then_emit: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV_GO && !sts.cfg_write |=> state_ff == ST_DIV_WAIT)
      else $error("divider start not followed by wait");
`endif

endmodule

`default_nettype wire

[rtl/nary_huffman_code_builder_core.sv]
// ----------------------------------------------------------------------------
// nary_huffman_code_builder_core: n-ary Huffman code builder
// Collects a set of symbol weights, builds the radix-ary code tree and
// returns each symbol's code with the weighted average code length.
// ----------------------------------------------------------------------------
// Usage:
//  csr_we/csr_index/csr_wdata write radix (index 0) or symbol_count (index 1)
//  while idle; a write drops a partly loaded set.
//  req_bus takes one weight per cycle, symbols in index order. After the last
//  weight of a set req_bus.ready stays low until every result has left.
//  Build: dummy padding first, then per taken node one scan of the node
//  store plus one merge per group of radix taken nodes; the scans dominate.
//  Code walk: a read step and an execute step per tree level per symbol;
//  then the restoring divider forms the average. rsp_bus then gives one
//  result per symbol in index order, each read from the result store before
//  it is shown; last marks the final symbol. A stalled rsp_bus holds the
//  result and the block waits. Reset is synchronous: radix 2, symbol_count 1,
//  empty set, ready to load on the next cycle; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module nary_huffman_code_builder_core import hcb_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_we,
   input  wire logic [CSR_IW-1:0] csr_index,
   input  wire logic [CSR_DW-1:0] csr_wdata,
   hcb_req_if.sink                req_bus,
   hcb_rsp_if.source              rsp_bus
);

   cmd_type cmd;
   sts_type sts;

   hcb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   hcb_datapath u_dp (
      .clock              (clock),
      .reset              (reset),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .weight             (req_bus.weight),
      .cmd                (cmd),
      .sts                (sts),
      .symbol             (rsp_bus.symbol),
      .code_length        (rsp_bus.code_length),
      .code_value         (rsp_bus.code_value),
      .average_hundredths (rsp_bus.average_hundredths),
      .last               (rsp_bus.last)
   );

endmodule

`default_nettype wire

[sim/tb_nary_huffman_code_builder_core.sv]
// ----------------------------------------------------------------------------
// tb_nary_huffman_code_builder_core: self-checking testbench
// Loads weight sets under many radix/symbol_count settings and checks every
// returned code against an in-bench tree builder, with random idle cycles on
// both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_nary_huffman_code_builder_core;
   import hcb_pkg::*;

   localparam int CYCLE_LIMIT = 3000000;
   localparam int ITEM_TARGET = 500;

   typedef struct {
      logic [SYM_W-1:0] symbol;
      logic [LEN_W-1:0] code_length;
      logic [VAL_W-1:0] code_value;
      logic [AVG_W-1:0] average_hundredths;
      logic             last;
   } code_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [CSR_IW-1:0] csr_index = '0;
   logic [CSR_DW-1:0] csr_wdata = '0;

   hcb_req_if req_bus ();
   hcb_rsp_if rsp_bus ();

   nary_huffman_code_builder_core u_top (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus)
   );

   code_item_type     expected_codes[$];
   logic [WEIGHT_W-1:0] loaded_weights[$];
   logic [RADIX_W-1:0]  cur_radix = 2;
   logic [SCOUNT_W-1:0] cur_symbols = 1;
   int errors = 0;
   int items_sent = 0;
   int cycles = 0;
   bit quiet = 0;
   int rsp_wait = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout at %0t", $time);
         $display("Simulation FAILED");
         $finish;
      end
   end

   // build the tree for the loaded set and queue one expected code per symbol
   function automatic void predict_codes();
      int r, n, leaves, cnt, active, best, id, k, j, steps;
      longint wt[MAX_NODES];
      int key[MAX_NODES], par[MAX_NODES], dig[MAX_NODES];
      bit act[MAX_NODES];
      longint sum, val, mul, total, weighted, avg;
      int lens[MAX_SYMBOLS];
      longint vals[MAX_SYMBOLS];
      code_item_type c;
      r = cur_radix < 2 ? 2 : (cur_radix > MAX_RADIX ? MAX_RADIX : cur_radix);
      n = cur_symbols < 1 ? 1 : (cur_symbols > MAX_SYMBOLS ? MAX_SYMBOLS : cur_symbols);
      leaves = n;
      while (leaves < r || (leaves - 1) % (r - 1) != 0) leaves++;
      for (int i = 0; i < leaves; i++) begin
         wt[i] = i < n ? loaded_weights[i] : 0;
         key[i] = i;
         act[i] = 1;
      end
      cnt = leaves;
      active = leaves;
      while (active > 1) begin
         id = cnt;
         sum = 0;
         k = 255;
         for (int d = 0; d < r; d++) begin
            best = -1;
            for (int i = 0; i < cnt; i++)
               if (act[i] && (best < 0 || wt[i] < wt[best] ||
                   (wt[i] == wt[best] && key[i] < key[best])))
                  best = i;
            act[best] = 0;
            par[best] = id;
            dig[best] = d;
            sum += wt[best];
            if (key[best] < k) k = key[best];
         end
         wt[cnt] = sum;
         key[cnt] = k;
         act[cnt] = 1;
         cnt++;
         active -= r - 1;
      end
      total = 0;
      weighted = 0;
      for (int i = 0; i < n; i++) begin
         j = i;
         steps = 0;
         val = 0;
         mul = 1;
         while (j != cnt - 1) begin
            val += dig[j] * mul;
            mul *= r;
            j = par[j];
            steps++;
         end
         lens[i] = steps;
         vals[i] = val;
         total += wt[i];
         weighted += wt[i] * steps;
      end
      avg = total != 0 ? (2 * weighted * 100 + total) / (2 * total) : 0;
      for (int i = 0; i < n; i++) begin
         c.symbol = SYM_W'(i);
         c.code_length = LEN_W'(lens[i]);
         c.code_value = VAL_W'(vals[i]);
         c.average_hundredths = AVG_W'(avg);
         c.last = (i == n - 1);
         expected_codes.push_back(c);
      end
      loaded_weights.delete();
   endfunction

   // result side: random stalls, compare each accepted item
   always @(posedge clock) begin
      code_item_type e;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rsp_wait <= 0;
      end else if (rsp_bus.ready && rsp_bus.valid) begin
         if (expected_codes.size() == 0) begin
            $display("%0t unexpected code: symbol %0d", $time, rsp_bus.symbol);
            errors++;
         end else begin
            e = expected_codes.pop_front();
            if (rsp_bus.symbol !== e.symbol || rsp_bus.code_length !== e.code_length ||
                rsp_bus.code_value !== e.code_value ||
                rsp_bus.average_hundredths !== e.average_hundredths ||
                rsp_bus.last !== e.last) begin
               $display("%0t mismatch exp sym %0d len %0d val %0d avg %0d last %0d",
                        $time, e.symbol, e.code_length, e.code_value,
                        e.average_hundredths, e.last);
               $display("%0t          got sym %0d len %0d val %0d avg %0d last %0d",
                        $time, rsp_bus.symbol, rsp_bus.code_length, rsp_bus.code_value,
                        rsp_bus.average_hundredths, rsp_bus.last);
               errors++;
            end
         end
         rsp_wait <= quiet ? 0 : $urandom_range(0, 10);
         rsp_bus.ready <= quiet || ($urandom_range(0, 10) == 0);
      end else if (!rsp_bus.ready) begin
         if (rsp_wait == 0) rsp_bus.ready <= 1'b1;
         else rsp_wait <= rsp_wait - 1;
      end
   end

   task automatic send_weight(input logic [WEIGHT_W-1:0] w);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.weight <= w;
      do @(posedge clock); while (!req_bus.ready);
      items_sent++;
      loaded_weights.push_back(w);
      if (loaded_weights.size() >= (cur_symbols < 1 ? 1 :
          (cur_symbols > MAX_SYMBOLS ? MAX_SYMBOLS : cur_symbols)))
         predict_codes();
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      while (expected_codes.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IW-1:0] idx, input logic [CSR_DW-1:0] data);
      wait_drained();
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == REG_RADIX) cur_radix = data[RADIX_W-1:0];
      else cur_symbols = data;
      loaded_weights.delete();
   endtask

   function automatic logic [WEIGHT_W-1:0] pick_weight(input int mode);
      case (mode)
         0: return WEIGHT_W'($urandom_range(0, 3));
         1: return '0;
         2: return 16'hFFFF;
         default: return WEIGHT_W'($urandom);
      endcase
   endfunction

   task automatic test_reset_defaults();
      send_weight(16'hFFFF);
      send_weight(16'h0000);
   endtask

   task automatic test_clamped_config();
      write_reg(REG_RADIX, 6'd0);
      write_reg(REG_SYMBOLS, 6'd0);
      send_weight(16'h5A5A);
      write_reg(REG_RADIX, 6'd31);
      write_reg(REG_SYMBOLS, 6'd3);
      send_weight(16'd7);
      send_weight(16'd7);
      send_weight(16'd7);
   endtask

   task automatic test_zero_weights();
      write_reg(REG_RADIX, 6'd1);
      write_reg(REG_SYMBOLS, 6'd4);
      repeat (4) send_weight(16'd0);
      write_reg(REG_RADIX, 6'd3);
      send_weight(16'd1);
      send_weight(16'd0);
      send_weight(16'hFFFF);
      send_weight(16'd1);
   endtask

   task automatic test_discard_partial();
      write_reg(REG_SYMBOLS, 6'd5);
      send_weight(16'd9);
      send_weight(16'd3);
      write_reg(REG_SYMBOLS, 6'd2);
      send_weight(16'd8);
      send_weight(16'd2);
   endtask

   task automatic test_random_sets();
      int n, sets, mode;
      logic [CSR_DW-1:0] r, s;
      while (items_sent < ITEM_TARGET) begin
         wait_drained();
         quiet = ($urandom_range(0, 3) == 0);
         case ($urandom_range(0, 4))
            0: r = CSR_DW'($urandom_range(0, 63));
            1: r = 6'd16;
            default: r = CSR_DW'($urandom_range(2, 16));
         endcase
         case ($urandom_range(0, 7))
            0: s = CSR_DW'($urandom_range(32, 63));
            1: s = 6'd0;
            2: s = CSR_DW'($urandom_range(11, 31));
            default: s = CSR_DW'($urandom_range(1, 10));
         endcase
         write_reg(REG_RADIX, r);
         write_reg(REG_SYMBOLS, s);
         n = s < 1 ? 1 : (s > MAX_SYMBOLS ? MAX_SYMBOLS : s);
         if (n > 1 && $urandom_range(0, 5) == 0) begin
            repeat ($urandom_range(1, n - 1)) send_weight(WEIGHT_W'($urandom));
            write_reg(REG_SYMBOLS, s);
         end
         sets = $urandom_range(1, 3);
         repeat (sets) begin
            mode = $urandom_range(0, 5);
            repeat (n) send_weight(pick_weight(mode == 5 ? $urandom_range(0, 3) : mode));
         end
      end
      quiet = 0;
   endtask

   initial begin
      req_bus.valid  = 1'b0;
      req_bus.weight = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_clamped_config();
      test_zero_weights();
      test_discard_partial();
      test_random_sets();
      wait_drained();
      repeat (200) @(posedge clock);
      if (errors == 0 && expected_codes.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
